// ===== src/ncsec_pkg.sv =====
// ----------------------------------------------------------------------------
// ncsec_pkg: command stream extent check shared types
// opcodes, payload beats, descriptor record and helpers
// ----------------------------------------------------------------------------
`default_nettype none
package ncsec_pkg;

  localparam int unsigned REGION_W    = 3;
  localparam int unsigned REGION_CNT  = 8;
  localparam int unsigned ADDR_W      = 40;

  // operations
  localparam logic [15:0] OPC_DMA_START = 16'h0010;
  localparam logic [15:0] OPC_CONV      = 16'h0002;
  localparam logic [15:0] OPC_DEPTHWISE = 16'h0003;
  localparam logic [15:0] OPC_POOL      = 16'h0005;
  localparam logic [15:0] OPC_ELTWISE   = 16'h0006;
  // register commands without payload
  localparam logic [15:0] OPC_IFM_PAD_TOP    = 16'h0100;
  localparam logic [15:0] OPC_IFM_PAD_LEFT   = 16'h0101;
  localparam logic [15:0] OPC_IFM_PAD_RIGHT  = 16'h0102;
  localparam logic [15:0] OPC_IFM_PAD_BOTTOM = 16'h0103;
  localparam logic [15:0] OPC_IFM_DEPTH      = 16'h0104;
  localparam logic [15:0] OPC_IFM_PREC       = 16'h0105;
  localparam logic [15:0] OPC_IFM_BCAST      = 16'h0108;
  localparam logic [15:0] OPC_IFM_WIDTH0     = 16'h010a;
  localparam logic [15:0] OPC_IFM_HEIGHT0    = 16'h010b;
  localparam logic [15:0] OPC_IFM_HEIGHT1    = 16'h010c;
  localparam logic [15:0] OPC_IFM_REGION     = 16'h010f;
  localparam logic [15:0] OPC_OFM_WIDTH      = 16'h0111;
  localparam logic [15:0] OPC_OFM_HEIGHT     = 16'h0112;
  localparam logic [15:0] OPC_OFM_DEPTH      = 16'h0113;
  localparam logic [15:0] OPC_OFM_PREC       = 16'h0114;
  localparam logic [15:0] OPC_OFM_WIDTH0     = 16'h011a;
  localparam logic [15:0] OPC_OFM_HEIGHT0    = 16'h011b;
  localparam logic [15:0] OPC_OFM_HEIGHT1    = 16'h011c;
  localparam logic [15:0] OPC_OFM_REGION     = 16'h011f;
  localparam logic [15:0] OPC_KERNEL_WIDTH   = 16'h0120;
  localparam logic [15:0] OPC_KERNEL_HEIGHT  = 16'h0121;
  localparam logic [15:0] OPC_WEIGHT_REGION  = 16'h0128;
  localparam logic [15:0] OPC_SCALE_REGION   = 16'h0129;
  localparam logic [15:0] OPC_DMA_SRC_REGION = 16'h0130;
  localparam logic [15:0] OPC_DMA_DST_REGION = 16'h0131;
  localparam logic [15:0] OPC_DMA_SIZE0      = 16'h0132;
  localparam logic [15:0] OPC_DMA_SIZE1      = 16'h0133;
  localparam logic [15:0] OPC_IFM2_BCAST     = 16'h0180;
  localparam logic [15:0] OPC_IFM2_PREC      = 16'h0185;
  localparam logic [15:0] OPC_IFM2_WIDTH0    = 16'h018a;
  localparam logic [15:0] OPC_IFM2_HEIGHT0   = 16'h018b;
  localparam logic [15:0] OPC_IFM2_HEIGHT1   = 16'h018c;
  localparam logic [15:0] OPC_IFM2_REGION    = 16'h018f;
  // register commands with payload
  localparam logic [15:0] OPC_IFM_BASE0    = 16'h4000;
  localparam logic [15:0] OPC_IFM_BASE1    = 16'h4001;
  localparam logic [15:0] OPC_IFM_BASE2    = 16'h4002;
  localparam logic [15:0] OPC_IFM_BASE3    = 16'h4003;
  localparam logic [15:0] OPC_IFM_STRIDE_X = 16'h4004;
  localparam logic [15:0] OPC_IFM_STRIDE_Y = 16'h4005;
  localparam logic [15:0] OPC_IFM_STRIDE_C = 16'h4006;
  localparam logic [15:0] OPC_OFM_BASE0    = 16'h4010;
  localparam logic [15:0] OPC_OFM_BASE1    = 16'h4011;
  localparam logic [15:0] OPC_OFM_BASE2    = 16'h4012;
  localparam logic [15:0] OPC_OFM_BASE3    = 16'h4013;
  localparam logic [15:0] OPC_OFM_STRIDE_X = 16'h4014;
  localparam logic [15:0] OPC_OFM_STRIDE_Y = 16'h4015;
  localparam logic [15:0] OPC_OFM_STRIDE_C = 16'h4016;
  localparam logic [15:0] OPC_WEIGHT_BASE  = 16'h4020;
  localparam logic [15:0] OPC_WEIGHT_LEN   = 16'h4021;
  localparam logic [15:0] OPC_SCALE_BASE   = 16'h4022;
  localparam logic [15:0] OPC_SCALE_LEN    = 16'h4023;
  localparam logic [15:0] OPC_DMA_SRC_OFS  = 16'h4030;
  localparam logic [15:0] OPC_DMA_DST_OFS  = 16'h4031;
  localparam logic [15:0] OPC_DMA_LEN      = 16'h4032;
  localparam logic [15:0] OPC_DMA_SSTRIDE0 = 16'h4033;
  localparam logic [15:0] OPC_DMA_SSTRIDE1 = 16'h4034;
  localparam logic [15:0] OPC_DMA_DSTRIDE0 = 16'h4035;
  localparam logic [15:0] OPC_DMA_DSTRIDE1 = 16'h4036;
  localparam logic [15:0] OPC_IFM2_BASE0    = 16'h4080;
  localparam logic [15:0] OPC_IFM2_BASE1    = 16'h4081;
  localparam logic [15:0] OPC_IFM2_BASE2    = 16'h4082;
  localparam logic [15:0] OPC_IFM2_BASE3    = 16'h4083;
  localparam logic [15:0] OPC_IFM2_STRIDE_X = 16'h4084;
  localparam logic [15:0] OPC_IFM2_STRIDE_Y = 16'h4085;
  localparam logic [15:0] OPC_IFM2_STRIDE_C = 16'h4086;

  localparam int unsigned PAYLOAD_BIT = 14;
  localparam logic [7:0]  BCAST_SCALAR = 8'h08;
  localparam logic [15:0] POOL_NO_IFM  = 16'h0004;
  localparam int unsigned NO_SCALE_BIT = 8;
  localparam int unsigned NO_REGION_BIT = 8;

  // elementwise modes without a second operand
  localparam logic [15:0] EW_UNARY_A = 16'h0005;
  localparam logic [15:0] EW_UNARY_B = 16'h0006;
  localparam logic [15:0] EW_UNARY_C = 16'h0007;
  localparam logic [15:0] EW_UNARY_D = 16'h0024;

  // feature map layouts
  localparam logic [1:0] FMT_NHWC    = 2'd0;
  localparam logic [1:0] FMT_NHCWB16 = 2'd1;

  // DMA modes
  localparam logic [1:0] DMA_MODE_1D = 2'd0;
  localparam logic [1:0] DMA_MODE_3D = 2'd2;

  // extent tasks, in issue order
  localparam int unsigned TASK_CNT  = 7;
  localparam logic [2:0]  TASK_IFM  = 3'd0;
  localparam logic [2:0]  TASK_IFM2 = 3'd1;
  localparam logic [2:0]  TASK_WGT  = 3'd2;
  localparam logic [2:0]  TASK_SCL  = 3'd3;
  localparam logic [2:0]  TASK_OFM  = 3'd4;
  localparam logic [2:0]  TASK_DSRC = 3'd5;
  localparam logic [2:0]  TASK_DDST = 3'd6;

  typedef struct packed {
    logic [31:0] word;
    logic        end_of_stream;
  } in_t;

  typedef struct packed {
    logic [REGION_W-1:0] region;
    logic [63:0]         max_extent;
    logic                is_output;
    logic                last;
  } out_t;

  typedef struct packed {
    logic [3:0][ADDR_W-1:0] ifm_base;
    logic [2:0][ADDR_W-1:0] ifm_stride;
    logic [3:0][ADDR_W-1:0] ofm_base;
    logic [2:0][ADDR_W-1:0] ofm_stride;
    logic [3:0][ADDR_W-1:0] ifm2_base;
    logic [2:0][ADDR_W-1:0] ifm2_stride;
    logic [5:0][15:0]       ifm_dims;
    logic [5:0][15:0]       ofm_dims;
    logic [2:0][15:0]       ifm2_dims;
    logic [2:0][15:0]       prec;
    logic [1:0][7:0]        bcast;
    logic [3:0][7:0]        pad;
    logic [4:0][REGION_W-1:0] opreg;
    logic [1:0][ADDR_W-1:0] ws_base;
    logic [1:0][31:0]       ws_len;
    logic [2:0][15:0]       dma_setup;
    logic [1:0][3:0]        dma_reg;
    logic [2:0][ADDR_W-1:0] dma_ol;
    logic [3:0][ADDR_W-1:0] dma_stride;
  } desc_t;

  function automatic logic [63:0] sext40(input logic [ADDR_W-1:0] v);
    return {{(64 - ADDR_W){v[ADDR_W-1]}}, v};
  endfunction

endpackage
`default_nettype wire

// ===== src/ncsec_stream_if.sv =====
// ----------------------------------------------------------------------------
// ncsec_stream_if: valid/ready stream channel
// one beat moves when valid and ready are both high
// ----------------------------------------------------------------------------
`default_nettype none
interface ncsec_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/npu_command_stream_extent_check.sv =====
// a payload word follows its header; operation words then run their extent tasks
// in turn on one shared 64x16 multiplier: feature map operands and DMA sides use it,
// weight and scale extents are a base plus a length.
// end of stream adds NUM_REGIONS report beats, one per cycle when out is ready.
// one word at a time; input ready only while idle.
// reset (and each end of stream) clears all descriptors and region records.
// ----------------------------------------------------------------------------
// npu_command_stream_extent_check: command stream extent checker
// decodes command words, tracks region extents, reports them at stream end
// ----------------------------------------------------------------------------
`default_nettype none
module npu_command_stream_extent_check #(
  parameter int unsigned NUM_REGIONS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ncsec_stream_if.sink   in_i,
  ncsec_stream_if.source out_o
);
  import ncsec_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_RUN    = 3'b010,
    S_REPORT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   await_q, await_d;
  logic [31:0] held_q, held_d;
  desc_t  cfg_q, cfg_d;
  logic [REGION_CNT-1:0][63:0] max_q, max_d;
  logic [REGION_CNT-1:0]       wr_q, wr_d;
  logic   eos_q, eos_d;
  logic [TASK_CNT-1:0] mask_q, mask_d;
  logic [2:0]  step_q, step_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] x_q, x_d, y_q, y_d;
  logic [15:0] c_q, c_d;
  logic [1:0]  tile_q, tile_d, fmt_q, fmt_d, esz_q, esz_d;
  logic [REGION_W-1:0] reg_q, reg_d, rpt_q, rpt_d;
  logic        skip_q, skip_d;
  out_t        out_q, out_d;
  logic        ov_q, ov_d;

  logic        acc_in, exec;
  logic [31:0] hdr, pay;
  logic [15:0] cmd, prm;
  logic [63:0] addr;
  logic [2:0]  cur;
  logic        side;
  logic [1:0]  dmode;
  logic [63:0] mul_a;
  logic [15:0] mul_b;
  logic [79:0] prod;
  logic        load, rpt_last;
  logic [REGION_W-1:0] rd_idx;
  logic [63:0] rd_max;

  // selected feature map operand
  logic [3:0][ADDR_W-1:0] f_base;
  logic [2:0][ADDR_W-1:0] f_str;
  logic [15:0] f_w0, f_h0, f_h1, f_prec, f_c;
  logic [31:0] f_x, f_y, f_w, f_h, f_xr, f_yr;
  logic [REGION_W-1:0] f_reg;
  logic        f_tx, f_ty;
  logic [31:0] mx;
  logic [ADDR_W-1:0] sx;
  logic [63:0] extra;

  assign acc_in = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign exec   = acc_in && (await_q || !in_i.data.word[PAYLOAD_BIT]);
  assign hdr    = await_q ? held_q : in_i.data.word;
  assign pay    = await_q ? in_i.data.word : 32'd0;
  assign cmd    = hdr[15:0];
  assign prm    = hdr[31:16];
  assign addr   = {24'd0, hdr[23:16], pay};
  assign side   = (cur == TASK_DDST);
  assign dmode  = cfg_q.dma_setup[2][1:0];
  assign prod   = {16'd0, mul_a} * {64'd0, mul_b};
  assign rpt_last = (rpt_q == REGION_W'(NUM_REGIONS - 1));
  assign load   = (state_q == S_REPORT) && (!ov_q || out_o.ready);
  assign rd_idx = (state_q == S_REPORT) ? rpt_q : reg_q;
  assign rd_max = max_q[rd_idx];

  always_comb begin
    cur = TASK_IFM;
    for (int i = TASK_CNT - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        cur = 3'(i);
      end
    end
  end

  always_comb begin
    unique case (cur)
      TASK_IFM: begin
        f_base = cfg_q.ifm_base;
        f_str  = cfg_q.ifm_stride;
        f_w0   = cfg_q.ifm_dims[3];
        f_h0   = cfg_q.ifm_dims[4];
        f_h1   = cfg_q.ifm_dims[5];
        f_prec = cfg_q.prec[0];
        f_reg  = cfg_q.opreg[0];
        f_y    = 32'(cfg_q.ofm_dims[1]) + 32'(cfg_q.ifm_dims[1])
               - (32'(cfg_q.pad[0]) + 32'(cfg_q.pad[3]));
        f_x    = 32'(cfg_q.ofm_dims[0]) + 32'(cfg_q.ifm_dims[0])
               - (32'(cfg_q.pad[1]) + 32'(cfg_q.pad[2]));
        f_c    = cfg_q.ifm_dims[2];
      end
      TASK_IFM2: begin
        f_base = cfg_q.ifm2_base;
        f_str  = cfg_q.ifm2_stride;
        f_w0   = cfg_q.ifm2_dims[0];
        f_h0   = cfg_q.ifm2_dims[1];
        f_h1   = cfg_q.ifm2_dims[2];
        f_prec = cfg_q.prec[2];
        f_reg  = cfg_q.opreg[2];
        f_x    = 32'(cfg_q.ifm_dims[2]);
        f_y    = 32'd0;
        f_c    = cfg_q.ofm_dims[2];
      end
      default: begin
        f_base = cfg_q.ofm_base;
        f_str  = cfg_q.ofm_stride;
        f_w0   = cfg_q.ofm_dims[3];
        f_h0   = cfg_q.ofm_dims[4];
        f_h1   = cfg_q.ofm_dims[5];
        f_prec = cfg_q.prec[1];
        f_reg  = cfg_q.opreg[1];
        f_x    = 32'(cfg_q.ofm_dims[0]);
        f_y    = 32'(cfg_q.ofm_dims[1]);
        f_c    = cfg_q.ofm_dims[2];
      end
    endcase
    f_w  = 32'(f_w0) + 32'd1;
    f_tx = (f_x >= f_w);
    f_xr = f_tx ? f_x - f_w : f_x;
    f_h  = 32'(f_tx ? f_h1 : f_h0) + 32'd1;
    f_ty = (f_y >= f_h);
    f_yr = f_ty ? f_y - f_h : f_y;
  end

  // x term operand and stride by layout
  always_comb begin
    unique case (fmt_q)
      FMT_NHWC: begin
        mx    = x_q;
        sx    = f_str[0];
        extra = 64'(c_q);
      end
      FMT_NHCWB16: begin
        mx    = 32'(c_q[15:4]);
        sx    = f_str[2];
        extra = 64'({x_q, c_q[3:0]}) << esz_q;
      end
      default: begin
        mx    = 32'd0;
        sx    = f_str[0];
        extra = 64'd0;
      end
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = 64'd0;
    mul_b = 16'd0;
    if (cur == TASK_DSRC || cur == TASK_DDST) begin
      mul_a = acc_q;
      mul_b = (step_q == 3'd1) ? cfg_q.dma_setup[0] : cfg_q.dma_setup[1];
    end else begin
      unique case (step_q)
        3'd1: begin mul_a = 64'(f_str[1]); mul_b = y_q[15:0]; end
        3'd2: begin mul_a = 64'(f_str[1]); mul_b = y_q[31:16]; end
        3'd3: begin mul_a = 64'(sx); mul_b = mx[15:0]; end
        3'd4: begin mul_a = 64'(sx); mul_b = mx[31:16]; end
        default: begin mul_a = 64'd0; mul_b = 16'd0; end
      endcase
    end
  end

  always_comb begin
    logic i2, ns, last_step;
    state_d = state_q;
    await_d = await_q;
    held_d  = held_q;
    cfg_d   = cfg_q;
    max_d   = max_q;
    wr_d    = wr_q;
    eos_d   = eos_q;
    mask_d  = mask_q;
    step_d  = step_q;
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    c_d     = c_q;
    tile_d  = tile_q;
    fmt_d   = fmt_q;
    esz_d   = esz_q;
    reg_d   = reg_q;
    skip_d  = skip_q;
    rpt_d   = rpt_q;
    out_d   = out_q;
    ov_d    = ov_q && !out_o.ready;
    i2      = 1'b0;
    ns      = cfg_q.prec[1][NO_SCALE_BIT];
    last_step = 1'b0;

    if (acc_in) begin
      if (await_q) begin
        await_d = 1'b0;
      end else if (in_i.data.word[PAYLOAD_BIT]) begin
        await_d = 1'b1;
        held_d  = in_i.data.word;
      end
    end

    if (exec) begin
      unique case (cmd)
        OPC_DMA_START: begin
          mask_d = TASK_CNT'(1) << TASK_DSRC | TASK_CNT'(1) << TASK_DDST;
          if (!cfg_q.dma_reg[1][3]) begin
            wr_d[cfg_q.dma_reg[1][2:0]] = 1'b1;
          end
        end
        OPC_CONV, OPC_DEPTHWISE: begin
          i2 = prm[0];
          mask_d = {1'b0, 1'b0, 1'b1, !ns, !i2, i2, 1'b1};
          wr_d[cfg_q.opreg[1]] = 1'b1;
        end
        OPC_POOL: begin
          mask_d = {1'b0, 1'b0, 1'b1, !ns, 1'b0, 1'b0, prm != POOL_NO_IFM};
          wr_d[cfg_q.opreg[1]] = 1'b1;
        end
        OPC_ELTWISE: begin
          i2 = !(cfg_q.bcast[1] == BCAST_SCALAR || prm == EW_UNARY_A ||
                 prm == EW_UNARY_B || prm == EW_UNARY_C || prm == EW_UNARY_D);
          mask_d = {1'b0, 1'b0, 1'b1, 1'b0, 1'b0, i2, cfg_q.bcast[0] != BCAST_SCALAR};
          wr_d[cfg_q.opreg[1]] = 1'b1;
        end
        OPC_KERNEL_WIDTH:   cfg_d.ifm_dims[0] = prm;
        OPC_KERNEL_HEIGHT:  cfg_d.ifm_dims[1] = prm;
        OPC_IFM_PAD_TOP:    cfg_d.pad[0] = {1'b0, prm[6:0]};
        OPC_IFM_PAD_LEFT:   cfg_d.pad[1] = {1'b0, prm[6:0]};
        OPC_IFM_PAD_RIGHT:  cfg_d.pad[2] = prm[7:0];
        OPC_IFM_PAD_BOTTOM: cfg_d.pad[3] = prm[7:0];
        OPC_IFM_DEPTH:      cfg_d.ifm_dims[2] = prm;
        OPC_IFM_PREC:       cfg_d.prec[0] = prm;
        OPC_IFM_BCAST:      cfg_d.bcast[0] = prm[7:0];
        OPC_IFM_REGION:     cfg_d.opreg[0] = prm[2:0];
        OPC_IFM_WIDTH0:     cfg_d.ifm_dims[3] = prm;
        OPC_IFM_HEIGHT0:    cfg_d.ifm_dims[4] = prm;
        OPC_IFM_HEIGHT1:    cfg_d.ifm_dims[5] = prm;
        OPC_IFM_BASE0, OPC_IFM_BASE1, OPC_IFM_BASE2, OPC_IFM_BASE3:
          cfg_d.ifm_base[cmd[1:0]] = addr[ADDR_W-1:0];
        OPC_IFM_STRIDE_X:   cfg_d.ifm_stride[0] = addr[ADDR_W-1:0];
        OPC_IFM_STRIDE_Y:   cfg_d.ifm_stride[1] = addr[ADDR_W-1:0];
        OPC_IFM_STRIDE_C:   cfg_d.ifm_stride[2] = addr[ADDR_W-1:0];
        OPC_OFM_WIDTH:      cfg_d.ofm_dims[0] = prm;
        OPC_OFM_HEIGHT:     cfg_d.ofm_dims[1] = prm;
        OPC_OFM_DEPTH:      cfg_d.ofm_dims[2] = prm;
        OPC_OFM_PREC:       cfg_d.prec[1] = prm;
        OPC_OFM_REGION:     cfg_d.opreg[1] = prm[2:0];
        OPC_OFM_WIDTH0:     cfg_d.ofm_dims[3] = prm;
        OPC_OFM_HEIGHT0:    cfg_d.ofm_dims[4] = prm;
        OPC_OFM_HEIGHT1:    cfg_d.ofm_dims[5] = prm;
        OPC_OFM_BASE0, OPC_OFM_BASE1, OPC_OFM_BASE2, OPC_OFM_BASE3:
          cfg_d.ofm_base[cmd[1:0]] = addr[ADDR_W-1:0];
        OPC_OFM_STRIDE_X:   cfg_d.ofm_stride[0] = addr[ADDR_W-1:0];
        OPC_OFM_STRIDE_Y:   cfg_d.ofm_stride[1] = addr[ADDR_W-1:0];
        OPC_OFM_STRIDE_C:   cfg_d.ofm_stride[2] = addr[ADDR_W-1:0];
        OPC_IFM2_BCAST:     cfg_d.bcast[1] = prm[7:0];
        OPC_IFM2_PREC:      cfg_d.prec[2] = prm;
        OPC_IFM2_REGION:    cfg_d.opreg[2] = prm[2:0];
        OPC_IFM2_WIDTH0:    cfg_d.ifm2_dims[0] = prm;
        OPC_IFM2_HEIGHT0:   cfg_d.ifm2_dims[1] = prm;
        OPC_IFM2_HEIGHT1:   cfg_d.ifm2_dims[2] = prm;
        OPC_IFM2_BASE0, OPC_IFM2_BASE1, OPC_IFM2_BASE2, OPC_IFM2_BASE3:
          cfg_d.ifm2_base[cmd[1:0]] = addr[ADDR_W-1:0];
        OPC_IFM2_STRIDE_X:  cfg_d.ifm2_stride[0] = addr[ADDR_W-1:0];
        OPC_IFM2_STRIDE_Y:  cfg_d.ifm2_stride[1] = addr[ADDR_W-1:0];
        OPC_IFM2_STRIDE_C:  cfg_d.ifm2_stride[2] = addr[ADDR_W-1:0];
        OPC_WEIGHT_REGION:  cfg_d.opreg[3] = prm[2:0];
        OPC_SCALE_REGION:   cfg_d.opreg[4] = prm[2:0];
        OPC_WEIGHT_BASE:    cfg_d.ws_base[0] = addr[ADDR_W-1:0];
        OPC_WEIGHT_LEN:     cfg_d.ws_len[0] = pay;
        OPC_SCALE_BASE:     cfg_d.ws_base[1] = addr[ADDR_W-1:0];
        OPC_SCALE_LEN:      cfg_d.ws_len[1] = pay;
        OPC_DMA_SRC_REGION: begin
          cfg_d.dma_reg[0]   = prm[NO_REGION_BIT] ? 4'h8 : {1'b0, prm[2:0]};
          cfg_d.dma_setup[2] = {14'd0, prm[10:9]};
        end
        OPC_DMA_DST_REGION:
          cfg_d.dma_reg[1] = prm[NO_REGION_BIT] ? 4'h8 : {1'b0, prm[2:0]};
        OPC_DMA_SIZE0:      cfg_d.dma_setup[0] = prm;
        OPC_DMA_SIZE1:      cfg_d.dma_setup[1] = prm;
        OPC_DMA_SSTRIDE0:   cfg_d.dma_stride[0] = addr[ADDR_W-1:0];
        OPC_DMA_SSTRIDE1:   cfg_d.dma_stride[1] = addr[ADDR_W-1:0];
        OPC_DMA_DSTRIDE0:   cfg_d.dma_stride[2] = addr[ADDR_W-1:0];
        OPC_DMA_DSTRIDE1:   cfg_d.dma_stride[3] = addr[ADDR_W-1:0];
        OPC_DMA_SRC_OFS:    cfg_d.dma_ol[0] = addr[ADDR_W-1:0];
        OPC_DMA_DST_OFS:    cfg_d.dma_ol[1] = addr[ADDR_W-1:0];
        OPC_DMA_LEN:        cfg_d.dma_ol[2] = addr[ADDR_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (acc_in) begin
          step_d = 3'd0;
          eos_d  = in_i.data.end_of_stream;
          rpt_d  = '0;
          if (mask_d != '0) begin
            state_d = S_RUN;
          end else if (in_i.data.end_of_stream) begin
            state_d = S_REPORT;
          end
        end
      end
      S_RUN: begin
        if (cur == TASK_WGT || cur == TASK_SCL) begin
          if (step_q == 3'd0) begin
            acc_d = 64'(cfg_q.ws_base[cur[0]]) + 64'(cfg_q.ws_len[cur[0]]);
            reg_d = cfg_q.opreg[3 + 32'(cur[0])];
            skip_d = 1'b0;
          end else begin
            last_step = 1'b1;
          end
        end else if (cur == TASK_DSRC || cur == TASK_DDST) begin
          unique case (step_q)
            3'd0: begin
              acc_d = 64'(cfg_q.dma_ol[2]) + ((dmode != DMA_MODE_1D) ?
                      sext40(cfg_q.dma_stride[{side, 1'b0}]) : 64'd0);
              reg_d  = cfg_q.dma_reg[side][2:0];
              skip_d = cfg_q.dma_reg[side][3];
            end
            3'd1: if (dmode != DMA_MODE_1D) acc_d = prod[63:0];
            3'd2: if (dmode == DMA_MODE_3D)
                    acc_d = acc_q + sext40(cfg_q.dma_stride[{side, 1'b1}]);
            3'd3: if (dmode == DMA_MODE_3D) acc_d = prod[63:0];
            3'd4: acc_d = acc_q + 64'(cfg_q.dma_ol[side]);
            default: last_step = 1'b1;
          endcase
        end else begin
          unique case (step_q)
            3'd0: begin
              x_d    = f_xr;
              y_d    = f_yr;
              c_d    = f_c;
              tile_d = {f_ty, f_tx};
              fmt_d  = f_prec[7:6];
              esz_d  = f_prec[2:1];
              reg_d  = f_reg;
              skip_d = 1'b0;
              acc_d  = 64'(f_base[{f_ty, f_tx}]);
            end
            3'd1, 3'd3: acc_d = acc_q + prod[63:0];
            3'd2, 3'd4: acc_d = acc_q + {prod[47:0], 16'd0};
            3'd5: acc_d = acc_q + extra + 64'd1;
            default: last_step = 1'b1;
          endcase
        end
        if (last_step) begin
          if (!skip_q && acc_q > rd_max) begin
            max_d[reg_q] = acc_q;
          end
          mask_d[cur] = 1'b0;
          step_d = 3'd0;
          if (mask_d == '0) begin
            state_d = eos_q ? S_REPORT : S_IDLE;
          end
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      S_REPORT: begin
        if (load) begin
          out_d.region     = rpt_q;
          out_d.max_extent = rd_max;
          out_d.is_output  = wr_q[rpt_q];
          out_d.last       = rpt_last;
          ov_d  = 1'b1;
          rpt_d = rpt_q + REGION_W'(1);
          if (rpt_last) begin
            state_d = S_IDLE;
            cfg_d   = '0;
            max_d   = '0;
            wr_d    = '0;
            await_d = 1'b0;
            held_d  = '0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      await_q <= 1'b0;
      held_q  <= '0;
      cfg_q   <= '0;
      max_q   <= '0;
      wr_q    <= '0;
      eos_q   <= 1'b0;
      mask_q  <= '0;
      step_q  <= '0;
      rpt_q   <= '0;
      ov_q    <= 1'b0;
      skip_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      await_q <= await_d;
      held_q  <= held_d;
      cfg_q   <= cfg_d;
      max_q   <= max_d;
      wr_q    <= wr_d;
      eos_q   <= eos_d;
      mask_q  <= mask_d;
      step_q  <= step_d;
      rpt_q   <= rpt_d;
      ov_q    <= ov_d;
      skip_q  <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    x_q    <= x_d;
    y_q    <= y_d;
    c_q    <= c_d;
    tile_q <= tile_d;
    fmt_q  <= fmt_d;
    esz_q  <= esz_d;
    reg_q  <= reg_d;
    out_q  <= out_d;
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = out_q;

  // tile is only latched for later inspection of the address path
  a_tile_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && step_q == 3'd0 && cur == TASK_OFM) |=>
      (tile_q == $past({f_ty, f_tx})))
    else $error("ofm tile latch mismatch");

  a_run_has_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (mask_q != '0))
    else $error("sequencer running with no task");

  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && rpt_last) |=> (wr_q == '0 && max_q == '0 && state_q == S_IDLE))
    else $error("state not cleared after report");

  a_region_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (32'(out_o.data.region) < NUM_REGIONS))
    else $error("reported region out of range");

endmodule
`default_nettype wire

// ===== tb/sv/ncsec_extent_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ncsec_extent_checker: region extent scoreboard
// watches the command and report channels, tracks the descriptor state of the
// stream, works out each region report and compares it beat by beat
// ----------------------------------------------------------------------------
`default_nettype none
module ncsec_extent_checker
  import ncsec_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   pending_o
);

  logic        wait_payload;
  logic [31:0] held_hdr;
  logic [63:0] ifm_base [4];
  logic [63:0] ifm_stride [3];
  logic [63:0] ofm_base [4];
  logic [63:0] ofm_stride [3];
  logic [63:0] ifm2_base [4];
  logic [63:0] ifm2_stride [3];
  logic [15:0] ifm_dim [6];
  logic [15:0] ofm_dim [6];
  logic [15:0] ifm2_dim [3];
  logic [15:0] prec [3];
  logic [7:0]  bcast [2];
  logic [7:0]  pad [4];
  logic [2:0]  opreg [5];
  logic [63:0] ws_base [2];
  logic [31:0] ws_len [2];
  logic [15:0] dma_set [3];
  logic [3:0]  dma_reg [2];
  logic [63:0] dma_ol [3];
  logic [63:0] dma_str [4];
  logic [63:0] reg_max [8];
  logic        reg_written [8];

  out_t report_q [$];
  int   fails;

  assign fail_count_o = fails;
  assign pending_o    = report_q.size();

  function automatic void clear_state();
    wait_payload = 1'b0;
    held_hdr     = '0;
    for (int i = 0; i < 4; i++) begin
      ifm_base[i] = '0; ofm_base[i] = '0; ifm2_base[i] = '0; dma_str[i] = '0;
      pad[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      ifm_stride[i] = '0; ofm_stride[i] = '0; ifm2_stride[i] = '0;
      ifm2_dim[i] = '0; prec[i] = '0; dma_set[i] = '0; dma_ol[i] = '0;
    end
    for (int i = 0; i < 6; i++) begin
      ifm_dim[i] = '0; ofm_dim[i] = '0;
    end
    for (int i = 0; i < 5; i++) opreg[i] = '0;
    for (int i = 0; i < 2; i++) begin
      bcast[i] = '0; ws_base[i] = '0; ws_len[i] = '0; dma_reg[i] = '0;
    end
    for (int i = 0; i < 8; i++) begin
      reg_max[i] = '0; reg_written[i] = 1'b0;
    end
  endfunction

  function automatic void raise_max(input logic [2:0] r, input logic [63:0] e);
    if (e > reg_max[r]) reg_max[r] = e;
  endfunction

  function automatic void fm_reach(input logic [63:0] bases [4],
                                   input logic [63:0] strides [3],
                                   input logic [15:0] w0, input logic [15:0] h0,
                                   input logic [15:0] h1, input logic [15:0] pr,
                                   input logic [2:0] r, input logic [31:0] xi,
                                   input logic [31:0] yi, input logic [31:0] c);
    logic [31:0] x, y, w, h;
    logic [1:0]  tile;
    logic [63:0] a, esz;
    x = xi;
    y = yi;
    tile = 2'd0;
    w = {16'd0, w0} + 32'd1;
    if (x >= w) begin
      x = x - w;
      tile = 2'd1;
    end
    h = {16'd0, (tile[0] ? h1 : h0)} + 32'd1;
    if (y >= h) begin
      y = y - h;
      tile = tile + 2'd2;
    end
    a = bases[tile] + {32'd0, y} * strides[1];
    case (pr[7:6])
      FMT_NHWC: a = a + {32'd0, x} * strides[0] + {32'd0, c};
      FMT_NHCWB16: begin
        esz = 64'd1 << pr[2:1];
        a = a + {32'd0, c >> 4} * strides[2]
              + (64'd16 * {32'd0, x} + {60'd0, c[3:0]}) * esz;
      end
      default: ;
    endcase
    raise_max(r, a + 64'd1);
  endfunction

  function automatic void run_op(input logic u_ifm, input logic u_ifm2,
                                 input logic u_w, input logic u_s);
    logic [31:0] x, y;
    if (u_ifm) begin
      y = {16'd0, ofm_dim[1]} + {16'd0, ifm_dim[1]}
        - ({24'd0, pad[0]} + {24'd0, pad[3]});
      x = {16'd0, ofm_dim[0]} + {16'd0, ifm_dim[0]}
        - ({24'd0, pad[1]} + {24'd0, pad[2]});
      fm_reach(ifm_base, ifm_stride, ifm_dim[3], ifm_dim[4], ifm_dim[5], prec[0],
               opreg[0], x, y, {16'd0, ifm_dim[2]});
    end
    if (u_ifm2)
      fm_reach(ifm2_base, ifm2_stride, ifm2_dim[0], ifm2_dim[1], ifm2_dim[2],
               prec[2], opreg[2], {16'd0, ifm_dim[2]}, 32'd0, {16'd0, ofm_dim[2]});
    if (u_w) raise_max(opreg[3], ws_base[0] + {32'd0, ws_len[0]});
    if (u_s) raise_max(opreg[4], ws_base[1] + {32'd0, ws_len[1]});
    fm_reach(ofm_base, ofm_stride, ofm_dim[3], ofm_dim[4], ofm_dim[5], prec[1],
             opreg[1], {16'd0, ofm_dim[0]}, {16'd0, ofm_dim[1]}, {16'd0, ofm_dim[2]});
    reg_written[opreg[1]] = 1'b1;
  endfunction

  function automatic void dma_reach(input int side);
    logic [63:0] len;
    len = dma_ol[2];
    if (dma_set[2] >= 16'd1) len = (len + dma_str[side*2]) * {48'd0, dma_set[0]};
    if (dma_set[2] == 16'd2) len = (len + dma_str[side*2+1]) * {48'd0, dma_set[1]};
    if (!dma_reg[side][3]) raise_max(dma_reg[side][2:0], len + dma_ol[side]);
  endfunction

  function automatic void apply_cmd(input logic [31:0] hdr, input logic [31:0] pl);
    logic [15:0] op, prm;
    logic [63:0] a;
    logic        no_scale, i2;
    op = hdr[15:0];
    prm = hdr[31:16];
    a = {24'd0, hdr[23:16], pl};
    no_scale = prec[1][NO_SCALE_BIT];
    case (op)
      OPC_DMA_START: begin
        dma_reach(0);
        dma_reach(1);
        if (!dma_reg[1][3]) reg_written[dma_reg[1][2:0]] = 1'b1;
      end
      OPC_CONV, OPC_DEPTHWISE: run_op(1'b1, prm[0], !prm[0], !no_scale);
      OPC_POOL: run_op(prm != POOL_NO_IFM, 1'b0, 1'b0, !no_scale);
      OPC_ELTWISE: begin
        i2 = !(bcast[1] == BCAST_SCALAR || prm == EW_UNARY_A || prm == EW_UNARY_B ||
               prm == EW_UNARY_C || prm == EW_UNARY_D);
        run_op(bcast[0] != BCAST_SCALAR, i2, 1'b0, 1'b0);
      end
      OPC_KERNEL_WIDTH:   ifm_dim[0] = prm;
      OPC_KERNEL_HEIGHT:  ifm_dim[1] = prm;
      OPC_IFM_PAD_TOP:    pad[0] = {1'b0, prm[6:0]};
      OPC_IFM_PAD_LEFT:   pad[1] = {1'b0, prm[6:0]};
      OPC_IFM_PAD_RIGHT:  pad[2] = prm[7:0];
      OPC_IFM_PAD_BOTTOM: pad[3] = prm[7:0];
      OPC_IFM_DEPTH:      ifm_dim[2] = prm;
      OPC_IFM_PREC:       prec[0] = prm;
      OPC_IFM_BCAST:      bcast[0] = prm[7:0];
      OPC_IFM_REGION:     opreg[0] = prm[2:0];
      OPC_IFM_WIDTH0:     ifm_dim[3] = prm;
      OPC_IFM_HEIGHT0:    ifm_dim[4] = prm;
      OPC_IFM_HEIGHT1:    ifm_dim[5] = prm;
      OPC_IFM_BASE0, OPC_IFM_BASE1, OPC_IFM_BASE2, OPC_IFM_BASE3:
        ifm_base[op[1:0]] = a;
      OPC_IFM_STRIDE_X:   ifm_stride[0] = a;
      OPC_IFM_STRIDE_Y:   ifm_stride[1] = a;
      OPC_IFM_STRIDE_C:   ifm_stride[2] = a;
      OPC_OFM_WIDTH:      ofm_dim[0] = prm;
      OPC_OFM_HEIGHT:     ofm_dim[1] = prm;
      OPC_OFM_DEPTH:      ofm_dim[2] = prm;
      OPC_OFM_PREC:       prec[1] = prm;
      OPC_OFM_REGION:     opreg[1] = prm[2:0];
      OPC_OFM_WIDTH0:     ofm_dim[3] = prm;
      OPC_OFM_HEIGHT0:    ofm_dim[4] = prm;
      OPC_OFM_HEIGHT1:    ofm_dim[5] = prm;
      OPC_OFM_BASE0, OPC_OFM_BASE1, OPC_OFM_BASE2, OPC_OFM_BASE3:
        ofm_base[op[1:0]] = a;
      OPC_OFM_STRIDE_X:   ofm_stride[0] = a;
      OPC_OFM_STRIDE_Y:   ofm_stride[1] = a;
      OPC_OFM_STRIDE_C:   ofm_stride[2] = a;
      OPC_IFM2_BCAST:     bcast[1] = prm[7:0];
      OPC_IFM2_PREC:      prec[2] = prm;
      OPC_IFM2_REGION:    opreg[2] = prm[2:0];
      OPC_IFM2_WIDTH0:    ifm2_dim[0] = prm;
      OPC_IFM2_HEIGHT0:   ifm2_dim[1] = prm;
      OPC_IFM2_HEIGHT1:   ifm2_dim[2] = prm;
      OPC_IFM2_BASE0, OPC_IFM2_BASE1, OPC_IFM2_BASE2, OPC_IFM2_BASE3:
        ifm2_base[op[1:0]] = a;
      OPC_IFM2_STRIDE_X:  ifm2_stride[0] = a;
      OPC_IFM2_STRIDE_Y:  ifm2_stride[1] = a;
      OPC_IFM2_STRIDE_C:  ifm2_stride[2] = a;
      OPC_WEIGHT_REGION:  opreg[3] = prm[2:0];
      OPC_SCALE_REGION:   opreg[4] = prm[2:0];
      OPC_WEIGHT_BASE:    ws_base[0] = a;
      OPC_WEIGHT_LEN:     ws_len[0] = pl;
      OPC_SCALE_BASE:     ws_base[1] = a;
      OPC_SCALE_LEN:      ws_len[1] = pl;
      OPC_DMA_SRC_REGION: begin
        dma_reg[0] = prm[NO_REGION_BIT] ? 4'd8 : {1'b0, prm[2:0]};
        dma_set[2] = {14'd0, prm[10:9]};
      end
      OPC_DMA_DST_REGION: dma_reg[1] = prm[NO_REGION_BIT] ? 4'd8 : {1'b0, prm[2:0]};
      OPC_DMA_SIZE0:      dma_set[0] = prm;
      OPC_DMA_SIZE1:      dma_set[1] = prm;
      OPC_DMA_SSTRIDE0, OPC_DMA_SSTRIDE1, OPC_DMA_DSTRIDE0, OPC_DMA_DSTRIDE1:
        dma_str[op - OPC_DMA_SSTRIDE0] = {{24{a[39]}}, a[39:0]};
      OPC_DMA_SRC_OFS:    dma_ol[0] = a;
      OPC_DMA_DST_OFS:    dma_ol[1] = a;
      OPC_DMA_LEN:        dma_ol[2] = a;
      default: ;
    endcase
  endfunction

  function automatic void take_word(input in_t b);
    out_t r;
    if (wait_payload) begin
      wait_payload = 1'b0;
      apply_cmd(held_hdr, b.word);
    end else if (b.word[PAYLOAD_BIT]) begin
      held_hdr = b.word;
      wait_payload = 1'b1;
    end else begin
      apply_cmd(b.word, 32'd0);
    end
    if (b.end_of_stream) begin
      for (int i = 0; i < REGION_CNT; i++) begin
        r.region     = i[REGION_W-1:0];
        r.max_extent = reg_max[i];
        r.is_output  = reg_written[i];
        r.last       = (i == REGION_CNT - 1);
        report_q.push_back(r);
      end
      clear_state();
    end
  endfunction

  initial begin
    fails = 0;
    clear_state();
  end

  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) take_word(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (report_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected report beat: region %0d extent %h out %b last %b",
                     out_data_i.region, out_data_i.max_extent,
                     out_data_i.is_output, out_data_i.last);
        end else begin
          e = report_q.pop_front();
          if (e != out_data_i) begin
            fails++;
            if (fails <= 10)
              $display("report mismatch: exp region %0d extent %h out %b last %b, got region %0d extent %h out %b last %b",
                       e.region, e.max_extent, e.is_output, e.last,
                       out_data_i.region, out_data_i.max_extent,
                       out_data_i.is_output, out_data_i.last);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/npu_command_stream_extent_check_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// npu_command_stream_extent_check_test: command stream extent check bench
// drives directed and random command streams with random gaps and stalls;
// the checker predicts and compares every region report
// ----------------------------------------------------------------------------
`default_nettype none
module npu_command_stream_extent_check_test;
  import ncsec_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_WORDS   = 310;

  localparam logic [15:0] REG_OPS [65] = '{
    OPC_IFM_PAD_TOP, OPC_IFM_PAD_LEFT, OPC_IFM_PAD_RIGHT, OPC_IFM_PAD_BOTTOM,
    OPC_IFM_DEPTH, OPC_IFM_PREC, OPC_IFM_BCAST, OPC_IFM_WIDTH0, OPC_IFM_HEIGHT0,
    OPC_IFM_HEIGHT1, OPC_IFM_REGION, OPC_OFM_WIDTH, OPC_OFM_HEIGHT, OPC_OFM_DEPTH,
    OPC_OFM_PREC, OPC_OFM_WIDTH0, OPC_OFM_HEIGHT0, OPC_OFM_HEIGHT1, OPC_OFM_REGION,
    OPC_KERNEL_WIDTH, OPC_KERNEL_HEIGHT, OPC_WEIGHT_REGION, OPC_SCALE_REGION,
    OPC_DMA_SRC_REGION, OPC_DMA_DST_REGION, OPC_DMA_SIZE0, OPC_DMA_SIZE1,
    OPC_IFM2_BCAST, OPC_IFM2_PREC, OPC_IFM2_WIDTH0, OPC_IFM2_HEIGHT0,
    OPC_IFM2_HEIGHT1, OPC_IFM2_REGION,
    OPC_IFM_BASE0, OPC_IFM_BASE1, OPC_IFM_BASE2, OPC_IFM_BASE3, OPC_IFM_STRIDE_X,
    OPC_IFM_STRIDE_Y, OPC_IFM_STRIDE_C, OPC_OFM_BASE0, OPC_OFM_BASE1, OPC_OFM_BASE2,
    OPC_OFM_BASE3, OPC_OFM_STRIDE_X, OPC_OFM_STRIDE_Y, OPC_OFM_STRIDE_C,
    OPC_WEIGHT_BASE, OPC_WEIGHT_LEN, OPC_SCALE_BASE, OPC_SCALE_LEN, OPC_DMA_SRC_OFS,
    OPC_DMA_DST_OFS, OPC_DMA_LEN, OPC_DMA_SSTRIDE0, OPC_DMA_SSTRIDE1,
    OPC_DMA_DSTRIDE0, OPC_DMA_DSTRIDE1, OPC_IFM2_BASE0, OPC_IFM2_BASE1,
    OPC_IFM2_BASE2, OPC_IFM2_BASE3, OPC_IFM2_STRIDE_X, OPC_IFM2_STRIDE_Y,
    OPC_IFM2_STRIDE_C
  };
  localparam logic [15:0] RUN_OPS [5] = '{
    OPC_DMA_START, OPC_CONV, OPC_DEPTHWISE, OPC_POOL, OPC_ELTWISE
  };

  logic clk_i;
  logic rst_ni;
  logic quiet;
  logic long_hold;
  int   fail_count;
  int   pending;
  int   idle_cycles;

  ncsec_stream_if #(.T(in_t))  cmd_ch ();
  ncsec_stream_if #(.T(out_t)) rpt_ch ();

  npu_command_stream_extent_check u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (rpt_ch)
  );

  ncsec_extent_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (cmd_ch.valid),
    .in_ready_i   (cmd_ch.ready),
    .in_data_i    (cmd_ch.data),
    .out_valid_i  (rpt_ch.valid),
    .out_ready_i  (rpt_ch.ready),
    .out_data_i   (rpt_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    rpt_ch.ready = 1'b0;
    quiet = 1'b0;
    long_hold = 1'b0;
  end

  // report side ready: random bursts, one long hold on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        rpt_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        rpt_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        rpt_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
  end

  // stall watchdog
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((cmd_ch.valid && cmd_ch.ready) || (rpt_ch.valid && rpt_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic put_beat(input logic [31:0] w, input logic eos);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= '{word: w, end_of_stream: eos};
    do @(posedge clk_i); while (!(cmd_ch.valid && cmd_ch.ready));
  endtask

  task automatic put_cmd(input logic [15:0] op, input logic [15:0] prm,
                         input logic [31:0] pl, input logic eos);
    if (op[PAYLOAD_BIT]) begin
      put_beat({prm, op}, 1'b0);
      put_beat(pl, eos);
    end else begin
      put_beat({prm, op}, eos);
    end
  endtask

  function automatic logic [15:0] pick_param(input logic [15:0] op);
    case (op)
      OPC_IFM_BCAST, OPC_IFM2_BCAST:
        if ($urandom_range(0, 1)) return {8'd0, BCAST_SCALAR};
      OPC_POOL:
        if ($urandom_range(0, 2) == 0) return POOL_NO_IFM;
      OPC_ELTWISE:
        case ($urandom_range(0, 5))
          0: return EW_UNARY_A;
          1: return EW_UNARY_B;
          2: return EW_UNARY_C;
          3: return EW_UNARY_D;
          default: ;
        endcase
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom_range(0, 15));
      2:    return 16'($urandom_range(0, 3));
      3:    return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_payload();
    case ($urandom_range(0, 3))
      0, 1: return 32'($urandom_range(0, 4096));
      2:    return $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item(input logic eos);
    logic [15:0] op;
    int k;
    k = $urandom_range(0, 99);
    if (k < 6) begin
      put_beat($urandom, eos);
    end else begin
      op = (k < 28) ? RUN_OPS[$urandom_range(0, 4)] : REG_OPS[$urandom_range(0, 64)];
      put_cmd(op, pick_param(op), pick_payload(), eos);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero descriptors, then report
    put_cmd(OPC_CONV, 16'h0000, 32'h0, 1'b1);
    // extremes of bases, pads and dims
    put_cmd(OPC_IFM_BASE0, 16'hffff, 32'hffffffff, 1'b0);
    put_cmd(OPC_IFM_PAD_TOP, 16'hffff, 32'h0, 1'b0);
    put_cmd(OPC_IFM_PAD_RIGHT, 16'h00ff, 32'h0, 1'b0);
    put_cmd(OPC_OFM_WIDTH, 16'hffff, 32'h0, 1'b0);
    put_cmd(OPC_OFM_PREC, 16'h0146, 32'h0, 1'b0);
    put_cmd(OPC_OFM_STRIDE_C, 16'h00ff, 32'hffffffff, 1'b0);
    put_cmd(OPC_DEPTHWISE, 16'h0001, 32'h0, 1'b0);
    put_cmd(OPC_POOL, POOL_NO_IFM, 32'h0, 1'b0);
    put_cmd(OPC_IFM_BCAST, {8'd0, BCAST_SCALAR}, 32'h0, 1'b0);
    put_cmd(OPC_ELTWISE, EW_UNARY_D, 32'h0, 1'b0);
    put_cmd(OPC_ELTWISE, 16'h0001, 32'h0, 1'b1);
    // dma modes, negative stride, no destination region
    put_cmd(OPC_DMA_SRC_REGION, 16'h0403, 32'h0, 1'b0);
    put_cmd(OPC_DMA_SIZE0, 16'h0003, 32'h0, 1'b0);
    put_cmd(OPC_DMA_SIZE1, 16'h0002, 32'h0, 1'b0);
    put_cmd(OPC_DMA_SSTRIDE0, 16'h0080, 32'h00000010, 1'b0);
    put_cmd(OPC_DMA_LEN, 16'h0000, 32'h00000100, 1'b0);
    put_cmd(OPC_DMA_DST_REGION, 16'h0100, 32'h0, 1'b0);
    put_cmd(OPC_DMA_START, 16'h0000, 32'h0, 1'b0);
    put_cmd(OPC_DMA_SRC_REGION, 16'h0605, 32'h0, 1'b0);
    put_cmd(OPC_DMA_START, 16'h0000, 32'h0, 1'b0);
    // unknown opcode, then stream end on a header waiting for payload
    put_beat(32'hffff_3fff, 1'b0);
    // report side held off while the report and later words queue up
    long_hold = 1'b1;
    while (rpt_ch.ready) @(posedge clk_i);
    put_beat({16'h1234, OPC_WEIGHT_BASE}, 1'b1);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - 80) quiet = 1'b1;
      random_item(i == RANDOM_WORDS - 1 || $urandom_range(0, 29) == 0);
    end
    cmd_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
